// ===== rtl/lat_pkg.sv =====
// Shared types, sizes and codes for the toroidal life automaton.
// No dependencies; the core and the row rule import this package.
`default_nettype none

package lat_pkg;

  // Board geometry
  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int MAX_DIM   = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);

  // Board memory: two banks of MAX_ROWS rows, one row per entry
  localparam int RAM_DEPTH = 2 * MAX_ROWS;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);

  // Generation sweep counter and live-cell summing
  localparam int K_W       = $clog2(MAX_ROWS + 2);
  localparam int GRP_BITS  = 8;
  localparam int NGRP      = (MAX_COLS + GRP_BITS - 1) / GRP_BITS;
  localparam int GRP_W     = $clog2(GRP_BITS + 1);
  localparam int SUM_W     = $clog2(MAX_ROWS * MAX_COLS + 1);

  // Field and register widths
  localparam int CFG_W     = 7;
  localparam int COUNT_W   = 13;
  localparam int COUNT_MAX = 8191;
  localparam int OP_W      = 2;
  localparam int IN_BITS   = OP_W + ROW_W + COL_W + 1;
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = 1 + COUNT_W;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [MAX_COLS-1:0] row_t;
  typedef logic [DIM_W-1:0]    dim_t;

  // Operation codes
  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_STEP  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Register indexes
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // Map a written dimension into 1..maxv
  function automatic dim_t clamp_dim(input logic [CFG_W-1:0] v, input int maxv);
    int vi;
    vi = int'(v);
    if (vi == 0) begin
      return dim_t'(1);
    end else if (vi > maxv) begin
      return dim_t'(maxv);
    end
    return dim_t'(vi);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/life_automaton_torus_core.sv =====
// Top level of the toroidal life automaton: control, generation pipeline, ports.
// Depends on lat_pkg, lat_ram (board memory) and lat_row_eval (row rule).
//
// Holds a board of up to 64 x 64 one-bit cells, sized by the rows and columns
// registers, in one RAM of two banks with one 64-bit row per entry. Each input
// item writes a cell, reads a cell, or advances the board one generation of
// B3/S23 with wraparound on both edges; every item returns one result with
// the cell value (reads only) and the live count. A cell write or read does
// one RAM read, then one modify/write back, before its result; a cell outside
// the board and an unused op go straight to the result. In a generation
// it reads one row per cycle from the memory's single read port, keeps the
// row above and the current row in registers, writes each new row into the
// other bank and sums live cells in a registered tree behind it. A register
// write clears both boards at once through per-row valid bits, so no
// clearing pass is needed. The next item is accepted while a result still
// waits on the output.
`default_nettype none

module life_automaton_torus_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_addr,
  input  wire logic [lat_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // s_tdata, from bit 0: op[1:0], row[7:2], col[13:8], alive[14], zero fill
  input  wire logic [lat_pkg::IN_W-1:0]      s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // m_tdata, from bit 0: cell_alive[0], live_count[13:1], zero fill
  output logic [lat_pkg::OUT_W-1:0]          m_tdata
);
  import lat_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_GEN   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]         state;
  dim_t               rows;
  dim_t               cols;
  logic               cur_b;
  logic [COUNT_W-1:0] live_total;
  logic [RAM_DEPTH-1:0] vld;

  // Latched item
  logic [OP_W-1:0]    op_q;
  logic [ROW_W-1:0]   row_q;
  logic [COL_W-1:0]   col_q;
  logic               alive_q;
  logic               res_cell;

  // Generation pipeline
  logic [K_W-1:0]     k;
  logic [K_W-1:0]     k_m1;
  dim_t               rows_m1;
  logic [ROW_W-1:0]   gen_addr;
  logic               rd_go;
  logic [K_W-1:0]     rd_tag;
  logic               rd_ok;
  row_t               up_row;
  row_t               mid_row;
  row_t               eval_row;
  logic               wr_go;
  logic [ROW_W-1:0]   wr_idx;
  row_t               wr_row;
  logic               grp_go;
  logic [GRP_W-1:0]   grp_cnt [NGRP];
  logic [SUM_W-1:0]   gen_sum;
  logic [SUM_W-1:0]   grp_total;
  logic [NGRP*GRP_BITS-1:0] wr_pad;
  logic               drain_done;

  // Output registers
  logic               m_cell;
  logic [COUNT_W-1:0] m_count;

  // Input fields
  logic [OP_W-1:0]    in_op;
  logic [ROW_W-1:0]   in_row;
  logic [COL_W-1:0]   in_col;
  logic               in_alive;
  logic               in_inside;

  // Memory ports
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  row_t               ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  row_t               ram_q;
  row_t               rd_data;
  logic               cell_bit;
  logic               cell_we;
  row_t               cell_wdata;

  assign in_op     = s_tdata[OP_W-1:0];
  assign in_row    = s_tdata[OP_W +: ROW_W];
  assign in_col    = s_tdata[OP_W+ROW_W +: COL_W];
  assign in_alive  = s_tdata[OP_W+ROW_W+COL_W];
  assign in_inside = (dim_t'(in_row) < rows) && (dim_t'(in_col) < cols);

  assign s_tready  = (state == S_IDLE);
  assign m_tdata   = OUT_W'({m_count, m_cell});

  // Sweep address: last row first, then rows 0 .. rows-1, then row 0 again
  always_comb begin
    k_m1    = k - 1'b1;
    rows_m1 = rows - 1'b1;
    if (k == '0) begin
      gen_addr = rows_m1[ROW_W-1:0];
    end else if (int'(k_m1) == int'(rows)) begin
      gen_addr = '0;
    end else begin
      gen_addr = k_m1[ROW_W-1:0];
    end
  end

  assign ram_raddr = (state == S_GEN) ? {cur_b, gen_addr} : {cur_b, in_row};

  // Rows never written since the last clear read as dead
  assign rd_data  = rd_ok ? ram_q : '0;
  assign cell_bit = rd_data[col_q];

  // Cell write back: modify one bit of the row just read
  always_comb begin
    cell_we    = (state == S_RD) && (op_q == OP_WRITE) && (cell_bit != alive_q);
    cell_wdata = rd_data;
    cell_wdata[col_q] = alive_q;
  end

  // Share the write port between generation rows and cell writes
  assign ram_we    = wr_go | cell_we;
  assign ram_waddr = wr_go ? {~cur_b, wr_idx} : {cur_b, row_q};
  assign ram_wdata = wr_go ? wr_row : cell_wdata;

  lat_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (RAM_DEPTH)
  ) u_board (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  lat_row_eval u_eval (
    .up   (up_row),
    .mid  (mid_row),
    .dn   (rd_data),
    .cols (cols),
    .nxt  (eval_row)
  );

  // Sum the per-group live counts of one new row
  always_comb begin
    wr_pad    = (NGRP*GRP_BITS)'(wr_row);
    grp_total = '0;
    for (int g = 0; g < NGRP; g++) begin
      grp_total = grp_total + SUM_W'(grp_cnt[g]);
    end
  end

  assign drain_done = !rd_go && !wr_go && !grp_go;

  // Datapath registers of the generation sweep
  always_ff @(posedge clk) begin
    rd_ok  <= vld[ram_raddr];
    rd_tag <= k;
    if (rd_go) begin
      up_row  <= mid_row;
      mid_row <= rd_data;
      wr_idx  <= ROW_W'(rd_tag - K_W'(2));
      wr_row  <= eval_row;
    end
    for (int g = 0; g < NGRP; g++) begin
      grp_cnt[g] <= GRP_W'($countones(wr_pad[g*GRP_BITS +: GRP_BITS]));
    end
    if (state == S_IDLE) begin
      gen_sum <= '0;
    end else if (grp_go) begin
      gen_sum <= gen_sum + grp_total;
    end
    if (s_tvalid && s_tready) begin
      op_q    <= in_op;
      row_q   <= in_row;
      col_q   <= in_col;
      alive_q <= in_alive;
    end
  end

  // Control, board status and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rows       <= dim_t'(MAX_ROWS);
      cols       <= dim_t'(MAX_COLS);
      cur_b      <= 1'b0;
      live_total <= '0;
      vld        <= '0;
      k          <= '0;
      rd_go      <= 1'b0;
      wr_go      <= 1'b0;
      grp_go     <= 1'b0;
      res_cell   <= 1'b0;
      m_tvalid   <= 1'b0;
      m_cell     <= 1'b0;
      m_count    <= '0;
    end else begin
      rd_go  <= (state == S_GEN);
      wr_go  <= rd_go && (rd_tag >= K_W'(2));
      grp_go <= wr_go;

      if (ram_we) begin
        vld[ram_waddr] <= 1'b1;
      end

      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            res_cell <= 1'b0;
            case (in_op) inside
              OP_WRITE, OP_READ: begin
                state <= in_inside ? S_RD : S_RESP;
              end
              OP_STEP: begin
                k     <= '0;
                state <= S_GEN;
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end
        end
        S_RD: begin
          res_cell <= (op_q == OP_READ) ? cell_bit : 1'b0;
          if (cell_we) begin
            if (alive_q) begin
              if (int'(live_total) < COUNT_MAX) begin
                live_total <= live_total + 1'b1;
              end
            end else if (live_total != '0) begin
              live_total <= live_total - 1'b1;
            end
          end
          state <= S_RESP;
        end
        S_GEN: begin
          k <= k + 1'b1;
          if (int'(k) == int'(rows) + 1) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (drain_done) begin
            live_total <= (int'(gen_sum) > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
                                                      : COUNT_W'(gen_sum);
            cur_b      <= ~cur_b;
            state      <= S_RESP;
          end
        end
        S_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_cell   <= res_cell;
            m_count  <= live_total;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // Any register write clears both boards
      if (cfg_we) begin
        if (cfg_addr == REG_ROWS) begin
          rows <= clamp_dim(cfg_data, MAX_ROWS);
        end else begin
          cols <= clamp_dim(cfg_data, MAX_COLS);
        end
        vld        <= '0;
        live_total <= '0;
        cur_b      <= 1'b0;
      end
    end
  end

  // A generation row never lands in the bank being read
  a_gen_other_bank: assert property (@(posedge clk) disable iff (rst)
    wr_go |-> (ram_waddr[ADDR_W-1] != cur_b))
    else $error("generation write targets the current bank");

  // Cell write back and generation writes never collide on the write port
  a_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(wr_go && (state == S_RD)))
    else $error("write port claimed twice");

  // Finishing a generation swaps the banks
  a_bank_swap: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DRAIN) && drain_done && !cfg_we) |=> (cur_b != $past(cur_b)))
    else $error("bank not swapped after generation");

  // The live count never exceeds the number of cells
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(live_total) <= MAX_ROWS * MAX_COLS)
    else $error("live count above board capacity");

endmodule

`default_nettype wire

// ===== rtl/lat_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module lat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/lat_row_eval.sv =====
// One-row life rule: next state of a full row from the rows above, at and below.
// Depends on lat_pkg for the row and dimension types.
`default_nettype none

module lat_row_eval (
  input  wire lat_pkg::row_t up,
  input  wire lat_pkg::row_t mid,
  input  wire lat_pkg::row_t dn,
  input  wire lat_pkg::dim_t cols,
  output lat_pkg::row_t      nxt
);
  import lat_pkg::*;

  localparam int BIRTH   = 3;
  localparam int SURVIVE = 2;

  // Neighbor to the left of each column, wrapping column 0 to the last used column
  function automatic row_t left_of(input row_t r, input dim_t n);
    dim_t nm1;
    nm1 = n - 1'b1;
    return {r[MAX_COLS-2:0], r[nm1[COL_W-1:0]]};
  endfunction

  // Neighbor to the right of each column, wrapping the last used column to column 0
  function automatic row_t right_of(input row_t r, input dim_t n);
    dim_t nm1;
    row_t redge;
    row_t rsh;
    nm1   = n - 1'b1;
    redge = row_t'(1) << nm1;
    rsh   = {r[0], r[MAX_COLS-1:1]};
    return (rsh & ~redge) | (redge & {MAX_COLS{r[0]}});
  endfunction

  row_t ul, ur, ml, mr, dl, dr;
  row_t inmask;
  row_t raw;
  logic [3:0] cnt;

  // Count neighbors per column and apply birth and survival
  always_comb begin
    ul     = left_of(up, cols);
    ur     = right_of(up, cols);
    ml     = left_of(mid, cols);
    mr     = right_of(mid, cols);
    dl     = left_of(dn, cols);
    dr     = right_of(dn, cols);
    inmask = ~(row_t'('1) << cols);
    raw    = '0;
    cnt    = '0;
    for (int c = 0; c < MAX_COLS; c++) begin
      cnt = 4'(ul[c]) + 4'(up[c]) + 4'(ur[c]) + 4'(ml[c]) +
            4'(mr[c]) + 4'(dl[c]) + 4'(dn[c]) + 4'(dr[c]);
      raw[c] = (cnt == 4'(BIRTH)) || (mid[c] && (cnt == 4'(SURVIVE)));
    end
    nxt = raw & inmask;
  end

endmodule

`default_nettype wire

// ===== dv/life_automaton_torus_core_tb.sv =====
// Self-checking testbench for life_automaton_torus_core: cell writes, reads and generations.
// Depends on lat_pkg and the core RTL; keeps its own board copy to predict every result.
`timescale 1ns / 1ps

module life_automaton_torus_core_tb;
  import lat_pkg::*;

  // Unused op code: leaves the board alone
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  localparam int ITEM_TARGET = 1950;
  localparam int IDLE_LIMIT  = 4000;
  localparam int SETTLE      = 12;
  localparam int TAIL_CYCLES = 80;

  typedef struct packed {
    logic               cell_val;
    logic [COUNT_W-1:0] count;
  } status_t;

  // Board copy, live count and the queue of results still owed by the block
  class board_tracker;
    bit [MAX_COLS-1:0] grid [2][MAX_ROWS];
    bit                bank;
    int                live;
    int                n_rows;
    int                n_cols;
    int                fail_count;
    status_t           expected_status[$];

    function new();
      n_rows     = MAX_ROWS;
      n_cols     = MAX_COLS;
      fail_count = 0;
      clear_boards();
    endfunction

    function void clear_boards();
      for (int b = 0; b < 2; b++) begin
        for (int r = 0; r < MAX_ROWS; r++) begin
          grid[b][r] = '0;
        end
      end
      bank = 1'b0;
      live = 0;
    endfunction

    // Any size write clamps into 1..max and wipes both boards
    function void set_dim(logic idx, logic [CFG_W-1:0] v);
      int lim;
      int d;
      lim = (idx == REG_ROWS) ? MAX_ROWS : MAX_COLS;
      d = int'(v);
      if (d == 0) begin
        d = 1;
      end else if (d > lim) begin
        d = lim;
      end
      if (idx == REG_ROWS) begin
        n_rows = d;
      end else begin
        n_cols = d;
      end
      clear_boards();
    endfunction

    // B3/S23 with wraparound; repeated neighbours on tiny boards count each time
    function void next_generation();
      int up, dn, lf, rt, n, total;
      bit nxt;
      total = 0;
      for (int r = 0; r < n_rows; r++) begin
        up = (r + n_rows - 1) % n_rows;
        dn = (r + 1) % n_rows;
        for (int c = 0; c < n_cols; c++) begin
          lf = (c + n_cols - 1) % n_cols;
          rt = (c + 1) % n_cols;
          n = grid[bank][up][lf] + grid[bank][up][c] + grid[bank][up][rt]
            + grid[bank][r][lf] + grid[bank][r][rt]
            + grid[bank][dn][lf] + grid[bank][dn][c] + grid[bank][dn][rt];
          nxt = grid[bank][r][c] ? (n == 2 || n == 3) : (n == 3);
          grid[!bank][r][c] = nxt;
          total += nxt;
        end
      end
      bank = !bank;
      live = (total > COUNT_MAX) ? COUNT_MAX : total;
    endfunction

    // Apply one accepted item and queue the status it produces
    function void apply_item(logic [OP_W-1:0] op, logic [ROW_W-1:0] r,
                             logic [COL_W-1:0] c, logic a);
      status_t st;
      bit in_board;
      in_board = (int'(r) < n_rows) && (int'(c) < n_cols);
      st.cell_val = 1'b0;
      case (op)
        OP_WRITE: begin
          if (in_board && grid[bank][r][c] != a) begin
            grid[bank][r][c] = a;
            if (a) begin
              if (live < COUNT_MAX) live++;
            end else begin
              if (live > 0) live--;
            end
          end
        end
        OP_STEP: begin
          next_generation();
        end
        OP_READ: begin
          if (in_board) st.cell_val = grid[bank][r][c];
        end
        default: begin
        end
      endcase
      st.count = live[COUNT_W-1:0];
      expected_status.push_back(st);
    endfunction

    task report(string what);
      $display("[%0t] tb mismatch: %s", $time, what);
      fail_count++;
    endtask

    // Compare one returned status with the oldest expectation
    task check_status(logic got_cell, logic [COUNT_W-1:0] count);
      status_t st;
      if (expected_status.size() == 0) begin
        report($sformatf("unexpected result cell=%0b count=%0d", got_cell, count));
      end else begin
        st = expected_status.pop_front();
        if (got_cell !== st.cell_val) begin
          report($sformatf("cell_alive got %0b want %0b", got_cell, st.cell_val));
        end
        if (count !== st.count) begin
          report($sformatf("live_count got %0d want %0d", count, st.count));
        end
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic               cfg_addr = 1'b0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  // s_tdata, from bit 0: op[1:0], row[7:2], col[13:8], alive[14], zero fill
  logic [IN_W-1:0]    s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  // m_tdata, from bit 0: cell_alive[0], live_count[13:1], zero fill
  logic [OUT_W-1:0]   m_tdata;

  board_tracker tracker = new();

  int items_sent  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  int rx_mode     = 0;
  int rx_left     = 0;
  int rx_run      = 0;
  bit rx_low      = 1'b0;
  int eff_rows    = MAX_ROWS;
  int eff_cols    = MAX_COLS;

  life_automaton_torus_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: switch at random between stall patterns
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(50, 400);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: begin
        if (rx_run == 0) begin
          rx_low = !rx_low;
          rx_run = rx_low ? $urandom_range(1, 16) : $urandom_range(1, 4);
        end else begin
          rx_run--;
        end
        m_tready <= !rx_low;
      end
      default: m_tready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      tracker.check_status(m_tdata[0], m_tdata[COUNT_W:1]);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("life_automaton_torus_core_tb: FAIL");
      $finish;
    end
  end

  // Send one item in bursts with random gaps; valid stays high across a burst
  task automatic send_item(input logic [OP_W-1:0] op, input int r, input int c,
                           input logic a);
    int gap;
    logic [ROW_W-1:0] rr;
    logic [COL_W-1:0] cc;
    rr = r[ROW_W-1:0];
    cc = c[COL_W-1:0];
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 3);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W-IN_BITS){1'b0}}, a, cc, rr, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.apply_item(op, rr, cc, a);
    items_sent++;
    burst_left--;
  endtask

  // Drain all results, let the block settle, then resize (which clears the board)
  task automatic set_board(input int rows_v, input int cols_v);
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (tracker.expected_status.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= REG_ROWS;
    cfg_data <= rows_v[CFG_W-1:0];
    @(posedge clk);
    tracker.set_dim(REG_ROWS, rows_v[CFG_W-1:0]);
    cfg_addr <= REG_COLS;
    cfg_data <= cols_v[CFG_W-1:0];
    @(posedge clk);
    tracker.set_dim(REG_COLS, cols_v[CFG_W-1:0]);
    cfg_we <= 1'b0;
    eff_rows = tracker.n_rows;
    eff_cols = tracker.n_cols;
  endtask

  // One board setting: seed a cluster of cells, then a random mix of ops
  task automatic run_phase(input int n_items);
    int density, p, seeds, win_r, win_c, off_r, off_c;
    density = $urandom_range(15, 60);
    win_r = (eff_rows < 8) ? eff_rows : 8;
    win_c = (eff_cols < 8) ? eff_cols : 8;
    off_r = $urandom_range(0, eff_rows - win_r);
    off_c = $urandom_range(0, eff_cols - win_c);
    seeds = $urandom_range(5, 30);
    repeat (seeds) begin
      send_item(OP_WRITE, off_r + $urandom_range(0, win_r - 1),
                off_c + $urandom_range(0, win_c - 1), $urandom_range(0, 99) < density);
    end
    repeat (n_items) begin
      p = $urandom_range(0, 99);
      if (p < 40) begin
        send_item(OP_WRITE, $urandom_range(0, eff_rows - 1), $urandom_range(0, eff_cols - 1),
                  $urandom_range(0, 99) < density);
      end else if (p < 45) begin
        send_item(OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                  1'($urandom_range(0, 1)));
      end else if (p < 65) begin
        send_item(OP_READ, $urandom_range(0, eff_rows - 1), $urandom_range(0, eff_cols - 1),
                  1'($urandom_range(0, 1)));
      end else if (p < 70) begin
        send_item(OP_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                  1'($urandom_range(0, 1)));
      end else if (p < 92) begin
        send_item(OP_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                  1'($urandom_range(0, 1)));
      end else begin
        send_item(OP_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    int preset_rows [7] = '{64, 1, 2, 1, 64, 3, 2};
    int preset_cols [7] = '{64, 1, 2, 64, 1, 3, 64};
    int phase_idx;
    int rv, cv;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Full board after reset: four corners form a block across both wraps
    send_item(OP_READ,  0,  0, 1'b0);
    send_item(OP_WRITE, 0,  0, 1'b1);
    send_item(OP_WRITE, 0,  0, 1'b1);
    send_item(OP_WRITE, 63, 63, 1'b1);
    send_item(OP_WRITE, 0,  63, 1'b1);
    send_item(OP_WRITE, 63, 0,  1'b1);
    send_item(OP_READ,  63, 63, 1'b0);
    send_item(OP_WRITE, 5,  5,  1'b0);
    send_item(OP_NONE,  63, 63, 1'b1);
    send_item(OP_STEP,  0,  0,  1'b0);
    send_item(OP_READ,  0,  0,  1'b0);
    send_item(OP_WRITE, 0,  0,  1'b0);
    send_item(OP_STEP,  0,  0,  1'b0);
    send_item(OP_READ,  0,  0,  1'b0);

    // Zero sizes count as one: the lone cell sees itself eight times
    set_board(0, 0);
    send_item(OP_WRITE, 0, 0, 1'b1);
    send_item(OP_STEP,  0, 0, 1'b0);
    send_item(OP_WRITE, 0, 0, 1'b1);
    send_item(OP_READ,  0, 0, 1'b0);
    send_item(OP_WRITE, 1, 0, 1'b1);
    send_item(OP_READ,  0, 1, 1'b0);

    // Oversized rows saturate; two columns repeat each side neighbour
    set_board(127, 2);
    send_item(OP_WRITE, 0, 0, 1'b1);
    send_item(OP_WRITE, 0, 1, 1'b1);
    send_item(OP_WRITE, 1, 0, 1'b1);
    send_item(OP_STEP,  0, 0, 1'b0);
    send_item(OP_READ,  0, 2, 1'b1);

    // Random phases: preset extremes first, then random sizes
    phase_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase_idx < 7) begin
        rv = preset_rows[phase_idx];
        cv = preset_cols[phase_idx];
      end else if ($urandom_range(0, 2) == 0) begin
        rv = $urandom_range(0, 127);
        cv = $urandom_range(0, 127);
      end else begin
        rv = $urandom_range(1, 16);
        cv = $urandom_range(1, 16);
      end
      set_board(rv, cv);
      run_phase($urandom_range(60, 180));
      phase_idx++;
    end

    // Drain, then watch for stray results
    s_tvalid <= 1'b0;
    while (tracker.expected_status.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.fail_count == 0) begin
      $display("life_automaton_torus_core_tb: PASS");
    end else begin
      $display("life_automaton_torus_core_tb: FAIL");
    end
    $finish;
  end

endmodule
